### hdl/grq_pkg.sv
// ----------------------------------------------------------------------------
// grq_pkg
// Shared types and command codes for the graph reachability query block.
// ----------------------------------------------------------------------------
package grq_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam int unsigned ID_W = 8;

endpackage

### hdl/grq_if.sv
// ----------------------------------------------------------------------------
// grq_in_if / grq_out_if
// Valid/ready channels for command items and query results.
// ----------------------------------------------------------------------------
interface grq_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [grq_pkg::ID_W-1:0]  node_from;
  logic [grq_pkg::ID_W-1:0]  node_to;
  modport source (output valid, cmd, node_from, node_to, input ready);
  modport sink   (input valid, cmd, node_from, node_to, output ready);
endinterface

interface grq_out_if;
  logic valid;
  logic ready;
  logic path_found;
  modport source (output valid, path_found, input ready);
  modport sink   (input valid, path_found, output ready);
endinterface

### hdl/grq_ram.sv
// ----------------------------------------------------------------------------
// grq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module grq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/graph_reachability_query.sv
// ----------------------------------------------------------------------------
// graph_reachability_query
// Directed graph reachability over byte node ids, adjacency in RAM.
// ----------------------------------------------------------------------------
// Input channel carries cmd, node_from, node_to; clear and add give no
// result, query gives one path_found item on the output channel.
// The adjacency matrix sits in one RAM of WORD_BITS-bit words, ROW_WORDS
// per node, plus a node-present RAM. One item is taken at a time.
// After reset, and after every clear, a clearing pass writes every row:
// all NODE_IDS*ROW_WORDS words (1024 by default), with no item accepted.
// Add edge: read-modify-write of one word, in ST_ARD then ST_AWR.
// An ignored add or an unused command frees the input on the next cycle.
// Query: level-by-level walk. Each level checks the target, then scans all
// ids; for an id in the frontier its ROW_WORDS row words are read in turn
// and ORed into the next frontier.
// A result waits in the output register while the receiver stalls; the next
// item is accepted only after it leaves.
// ----------------------------------------------------------------------------
module graph_reachability_query #(
  parameter int unsigned NODE_IDS  = 256,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic clk,
  input  logic rst_n,
  grq_in_if.sink    in_ch,
  grq_out_if.source out_ch
);
  localparam int unsigned ROW_WORDS = (NODE_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned SET_BITS  = ROW_WORDS * WORD_BITS;
  localparam int unsigned NID_W     = (NODE_IDS > 1) ? $clog2(NODE_IDS) : 1;
  localparam int unsigned RW_W      = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int unsigned ADEPTH    = NODE_IDS * ROW_WORDS;
  localparam int unsigned AA_W      = $clog2(ADEPTH);
  localparam int unsigned SCAN_W    = NID_W + 1;
  localparam int unsigned WB_W      = $clog2(WORD_BITS);

  typedef enum logic [9:0] {
    ST_CLR   = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_ARD   = 10'b0000000100,
    ST_AWR   = 10'b0000001000,
    ST_QPRE  = 10'b0000010000,
    ST_QCHK  = 10'b0000100000,
    ST_SCAN  = 10'b0001000000,
    ST_RDW   = 10'b0010000000,
    ST_NEXT  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [AA_W-1:0]     clr_r, clr_nxt;
  logic [NID_W-1:0]    src_r, src_nxt, dst_r, dst_nxt;
  logic [SET_BITS-1:0] vis_r, vis_nxt, fr_r, fr_nxt, nx_r, nx_nxt;
  logic [SCAN_W-1:0]   n_r, n_nxt;
  logic [RW_W-1:0]     w_r, w_nxt;
  logic                rv_r, rv_nxt;
  logic [RW_W-1:0]     rw_r, rw_nxt;
  logic                res_r, res_nxt;

  logic                 a_we, p_we, p_wdata, p_rdata;
  logic [AA_W-1:0]      a_waddr, a_raddr;
  logic [WORD_BITS-1:0] a_wdata, a_rdata;
  logic [NID_W-1:0]     p_waddr, p_raddr;
  logic                 ids_ok;
  logic [RW_W-1:0]      dst_w;

  grq_ram #(.WIDTH(WORD_BITS), .DEPTH(ADEPTH)) u_adj (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  grq_ram #(.WIDTH(1), .DEPTH(NODE_IDS)) u_pres (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  function automatic logic [AA_W-1:0] word_addr(logic [NID_W-1:0] id,
                                                logic [RW_W-1:0] w);
    logic [AA_W+RW_W+NID_W:0] t;
    begin
      t = (AA_W+RW_W+NID_W+1)'(id) * (AA_W+RW_W+NID_W+1)'(ROW_WORDS)
          + (AA_W+RW_W+NID_W+1)'(w);
      return t[AA_W-1:0];
    end
  endfunction

  assign ids_ok = (32'(in_ch.node_from) < NODE_IDS) && (32'(in_ch.node_to) < NODE_IDS);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.path_found = res_r;
  assign dst_w = RW_W'(dst_r >> WB_W);

  logic [NID_W-1:0] n_id;
  assign n_id = n_r[NID_W-1:0];

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    src_nxt = src_r;
    dst_nxt = dst_r;
    vis_nxt = vis_r;
    fr_nxt = fr_r;
    nx_nxt = nx_r;
    n_nxt = n_r;
    w_nxt = w_r;
    rv_nxt = 1'b0;
    rw_nxt = w_r;
    res_nxt = res_r;
    a_we = 1'b0;
    a_waddr = clr_r;
    a_wdata = '0;
    a_raddr = word_addr(src_r, w_r);
    p_we = 1'b0;
    p_waddr = src_r;
    p_wdata = 1'b0;
    p_raddr = src_r;
    case (state_r)
      ST_CLR: begin
        a_we = 1'b1;
        a_waddr = clr_r;
        a_wdata = '0;
        if (32'(clr_r) < NODE_IDS) begin
          p_we = 1'b1;
          p_waddr = clr_r[NID_W-1:0];
          p_wdata = 1'b0;
        end
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == ADEPTH - 1) begin
          state_nxt = ST_IDLE;
          clr_nxt = '0;
        end
      end
      ST_IDLE: begin
        src_nxt = in_ch.node_from[NID_W-1:0];
        dst_nxt = in_ch.node_to[NID_W-1:0];
        if (in_ch.valid) begin
          case (grq_pkg::cmd_t'(in_ch.cmd))
            grq_pkg::CMD_CLEAR: state_nxt = ST_CLR;
            grq_pkg::CMD_ADD:   state_nxt = ids_ok ? ST_ARD : ST_IDLE;
            grq_pkg::CMD_QUERY: begin
              if (ids_ok) begin
                state_nxt = ST_QPRE;
              end else begin
                res_nxt = 1'b0;
                state_nxt = ST_OUT;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ARD: begin
        a_raddr = word_addr(src_r, dst_w);
        p_we = 1'b1;
        p_waddr = src_r;
        p_wdata = 1'b1;
        state_nxt = ST_AWR;
      end
      ST_AWR: begin
        a_we = 1'b1;
        a_waddr = word_addr(src_r, dst_w);
        a_wdata = a_rdata;
        a_wdata[WB_W'(dst_r)] = 1'b1;
        p_we = 1'b1;
        p_waddr = dst_r;
        p_wdata = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_QPRE: begin
        vis_nxt = '0;
        fr_nxt = '0;
        vis_nxt[src_r] = 1'b1;
        fr_nxt[src_r] = 1'b1;
        nx_nxt = '0;
        n_nxt = '0;
        w_nxt = '0;
        state_nxt = ST_QCHK;
      end
      ST_QCHK: begin
        if (!p_rdata) begin
          res_nxt = 1'b0;
          state_nxt = ST_OUT;
        end else if (fr_r[dst_r]) begin
          res_nxt = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (32'(n_r) == NODE_IDS) begin
          state_nxt = ST_NEXT;
        end else if (fr_r[n_id]) begin
          a_raddr = word_addr(n_id, '0);
          rv_nxt = 1'b1;
          rw_nxt = '0;
          w_nxt = (ROW_WORDS > 1) ? RW_W'(1) : '0;
          state_nxt = (ROW_WORDS > 1) ? ST_RDW : ST_SCAN;
          if (ROW_WORDS == 1) n_nxt = n_r + 1'b1;
        end else begin
          n_nxt = n_r + 1'b1;
        end
      end
      ST_RDW: begin
        a_raddr = word_addr(n_id, w_r);
        rv_nxt = 1'b1;
        rw_nxt = w_r;
        if (32'(w_r) == ROW_WORDS - 1) begin
          w_nxt = '0;
          n_nxt = n_r + 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end
      ST_NEXT: begin
        if (rv_r) begin
          state_nxt = ST_NEXT;
        end else begin
          fr_nxt = nx_r & ~vis_r;
          vis_nxt = vis_r | (nx_r & ~vis_r);
          nx_nxt = '0;
          n_nxt = '0;
          if ((nx_r & ~vis_r) == '0) begin
            res_nxt = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_QCHK;
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (rv_r) begin
      nx_nxt[32'(rw_r)*WORD_BITS +: WORD_BITS] =
        nx_r[32'(rw_r)*WORD_BITS +: WORD_BITS] | a_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      rv_r <= 1'b0;
      res_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      rv_r <= rv_nxt;
      res_r <= res_nxt;
    end
    src_r <= src_nxt;
    dst_r <= dst_nxt;
    vis_r <= vis_nxt;
    fr_r <= fr_nxt;
    nx_r <= nx_nxt;
    n_r <= n_nxt;
    w_r <= w_nxt;
    rw_r <= rw_nxt;
  end
endmodule
